// ----- hw/rtl/b64e_pkg.sv -----
// Shared types and constants for the base64 stream encoder.
// Holds the queue entry type and the sextet-to-character mapping.
// Depends on nothing.
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    // One group of up to three bytes waiting to be turned into characters.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  held;
        logic        last;
    } t_group;

    function automatic logic [7:0] sextet_char(input logic [5:0] s);
        logic [7:0] c;
        c = PAD_CHAR;
        case (s) inside
            [6'd0:6'd25]:  c = 8'h41 + {2'b00, s};
            [6'd26:6'd51]: c = 8'h61 + {2'b00, s} - 8'd26;
            [6'd52:6'd61]: c = 8'h30 + {2'b00, s} - 8'd52;
            6'd62:         c = PLUS_CHAR;
            6'd63:         c = SLASH_CHAR;
            default:       c = PAD_CHAR;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/base64_stream_encoder.sv -----
// Top level of the base64 stream encoder.
// Instantiates b64e_front, b64e_fifo and b64e_back; depends on b64e_pkg.
//
// Encodes a byte stream to base64 characters (standard alphabet, '=' padding)
// and marks the last character of each message. A byte is accepted in any cycle
// in which the group queue has room, so while it has room bytes are taken at
// one per cycle. Every closed group, full or final partial, yields four characters
// at one per cycle while the output is not stalled, from a registered output
// stage, so that port sets the sustained rate, at four characters per group.
// The group queue holds QUEUE_DEPTH groups, which lets the input keep moving while
// the output is stalled. There is no clearing pass after reset.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    b64e_pkg::t_group push_group;
    b64e_pkg::t_group pop_group;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_full           (full),
        .o_push           (push),
        .o_group          (push_group)
    );

    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_group),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_data  (pop_group),
        .o_empty     (empty)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_group     (pop_group),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ----- hw/rtl/b64e_front.sv -----
// Front part of the base64 stream encoder: accepts bytes and builds groups.
// A finished or final partial group is pushed into the queue.
// Depends on b64e_pkg.
module b64e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_message,
    input  logic              i_full,
    output logic              o_push,
    output b64e_pkg::t_group  o_group
);

    logic [15:0] r_pending;
    logic [15:0] n_pending;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [1:0]  pos;
    logic        accept;
    logic        close_group;

    assign o_ready     = !i_full;
    assign accept      = i_valid && o_ready;
    assign pos         = (r_pos == 2'd3) ? 2'd0 : r_pos;
    assign close_group = i_end_of_message || (pos == 2'd2);
    assign o_push      = accept && close_group;

    always_comb begin
        o_group.held = pos + 2'd1;
        o_group.last = i_end_of_message;
        case (pos)
            2'd0:    o_group.bits = {i_data_byte, 16'h0000};
            2'd1:    o_group.bits = {r_pending[15:8], i_data_byte, 8'h00};
            default: o_group.bits = {r_pending, i_data_byte};
        endcase
    end

    always_comb begin
        n_pending = r_pending;
        n_pos     = r_pos;
        if (accept) begin
            if (close_group) begin
                n_pos = 2'd0;
            end else begin
                n_pos = pos + 2'd1;
                if (pos == 2'd0) begin
                    n_pending = {i_data_byte, 8'h00};
                end else begin
                    n_pending = {r_pending[15:8], i_data_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- hw/rtl/b64e_fifo.sv -----
// Short queue of groups between the front and back parts of the encoder.
// Register-based, one push and one pop port.
// Depends on b64e_pkg.
module b64e_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64e_pkg::t_group  i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output b64e_pkg::t_group  o_pop_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/b64e_back.sv -----
// Back part of the base64 stream encoder: turns one group into four characters.
// Emits one character per cycle while the output is not stalled, through a registered output stage.
// Depends on b64e_pkg.
module b64e_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  b64e_pkg::t_group  i_group,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_char,
    output logic              o_last_char
);

    b64e_pkg::t_group r_cur;
    logic             r_active;
    logic [1:0]       r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             advance;
    logic [5:0]       sextet;
    logic [7:0]       char_now;

    assign advance = r_active && (!r_out_valid || i_ready);
    assign o_pop   = !i_empty && (!r_active || (advance && (r_idx == 2'd3)));

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_cur.bits[23:18];
            2'd1:    sextet = r_cur.bits[17:12];
            2'd2:    sextet = r_cur.bits[11:6];
            default: sextet = r_cur.bits[5:0];
        endcase
        char_now = (r_idx > r_cur.held) ? b64e_pkg::PAD_CHAR
                                        : b64e_pkg::sextet_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_group;
        end
        if (advance) begin
            r_out_char <= char_now;
            r_out_last <= r_cur.last && (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_idx <= 2'd0;
            end else if (advance) begin
                r_idx <= r_idx + 2'd1;
            end
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (advance && (r_idx == 2'd3)) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

// ----- hw/rtl/b64e_checker.sv -----
// Port-level checks for the base64 stream encoder, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder.
module b64e_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [7:0] o_out_char,
    input  logic       o_last_char
);

    logic r_pad_open;

    // Set after a non-final pad character; the next character must be the final pad.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_open <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_pad_open <= (o_out_char == b64e_pkg::PAD_CHAR) && !o_last_char;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_char) && $stable(o_last_char)))
        else $error("output item changed while stalled");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_out_char >= 8'h41 && o_out_char <= 8'h5A) ||
                     (o_out_char >= 8'h61 && o_out_char <= 8'h7A) ||
                     (o_out_char >= 8'h30 && o_out_char <= 8'h39) ||
                     o_out_char == b64e_pkg::PLUS_CHAR ||
                     o_out_char == b64e_pkg::SLASH_CHAR ||
                     o_out_char == b64e_pkg::PAD_CHAR))
        else $error("output character outside the base64 alphabet");

    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad_open && o_valid) |-> (o_out_char == b64e_pkg::PAD_CHAR && o_last_char))
        else $error("first pad not followed by the final pad");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_out_char       (o_out_char),
    .o_last_char      (o_last_char)
);
